// File: rtl/fcap_pkg.sv
package fcap_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 3;
  localparam int IDENT_W  = 10;
  localparam int SPACE_W  = 8;
  localparam int POLICY_W = 2;
  localparam int COUNT_W  = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOM_COUNT = 2'd1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd2;

  // Fit policies; any other code behaves as first fit
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [SPACE_W-1:0] cap;
    logic [SPACE_W-1:0] rem;
    logic               prio;
  } bin_entry_t;

  typedef struct packed {
    logic [SPACE_W-1:0]  size;
    logic                prio;
    logic [POLICY_W-1:0] policy;
  } cmp_req_t;

endpackage

// File: rtl/fcap_store.sv
module fcap_store import fcap_pkg::*; #(
  parameter int MAX_BINS = 8,
  localparam int SW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [SW-1:0]   wr_addr,
  input  bin_entry_t      wr_entry,
  input  logic            restart,
  input  logic [SW-1:0]   rd_addr,
  output bin_entry_t      rd_entry
);

  bin_entry_t mem [MAX_BINS];
  bin_entry_t rd_raw;
  logic       rd_valid;
  logic       rd_fresh;

  // An entry is valid once written; a fresh entry reads its remaining
  // space as its capacity (set by load and by restart, cleared by a nonzero debit).
  logic [MAX_BINS-1:0] valid;
  logic [MAX_BINS-1:0] fresh;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      fresh    <= '0;
      rd_valid <= 1'b0;
      rd_fresh <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      rd_fresh <= fresh[rd_addr];
      if (restart) begin
        fresh <= '1;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
        fresh[wr_addr] <= (wr_entry.rem == wr_entry.cap);
      end
    end
  end

  always_comb begin
    if (rd_valid) begin
      rd_entry = rd_raw;
      if (rd_fresh) begin
        rd_entry.rem = rd_raw.cap;
      end
    end else begin
      rd_entry = '0;
    end
  end

endmodule

// File: rtl/fcap_cmp.sv
module fcap_cmp import fcap_pkg::*; (
  input  bin_entry_t         entry,
  input  cmp_req_t           req,
  input  logic               found,
  input  logic [SPACE_W-1:0] best_rem,
  output logic               take
);

  logic eligible;

  // Strict compares keep ties on the lowest slot.
  always_comb begin
    eligible = !(req.prio && !entry.prio) && (entry.rem >= req.size);
    take     = 1'b0;
    if (eligible) begin
      if (!found) begin
        take = 1'b1;
      end else if (req.policy == POLICY_BEST) begin
        take = entry.rem < best_rem;
      end else if (req.policy == POLICY_WORST) begin
        take = entry.rem > best_rem;
      end
    end
  end

endmodule

// File: rtl/fit_policy_capacity_allocator.sv
// Channel   Ports                                              Handshake
// --------  -------------------------------------------------  --------------------------
// command   cmd, room_*_in, request_size, request_priority     start && !busy
// result    placed, room_ident_out, room_slot_out, space_left  done, one cycle, no stall
// config    cfg_index, cfg_data                                cfg_valid && cfg_ready
//
// Load, restart, unused codes and empty scans keep busy low; done is high in the cycle
// after acceptance. An allocate reads one bin per cycle through the registered store
// port into the shared fit compare; done follows once the scan of room_count bins
// (saturated at MAX_BINS) is through, and busy drops with done, so a new item can only
// follow with the result. Reset (rst, synchronous) clears the control and config
// registers and marks every bin empty at once; the receiver cannot stall results.
module fit_policy_capacity_allocator import fcap_pkg::*; #(
  parameter int MAX_BINS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [SLOT_W-1:0]     room_slot_in,
  input  logic [IDENT_W-1:0]    room_ident_in,
  input  logic [SPACE_W-1:0]    room_cap_in,
  input  logic                  room_priority_in,
  input  logic [SPACE_W-1:0]    request_size,
  input  logic                  request_priority,
  // result channel
  output logic                  done,
  output logic                  placed,
  output logic [IDENT_W-1:0]    room_ident_out,
  output logic [SLOT_W-1:0]     room_slot_out,
  output logic [SPACE_W-1:0]    space_left,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  // Scan counter holds the scan length itself, up to MAX_BINS or room_count.
  localparam int CW = (SW + 1 > COUNT_W) ? SW + 1 : COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t              state;
  logic [POLICY_W-1:0] fit_policy;
  logic [COUNT_W-1:0]  room_count;

  // Request under work
  cmp_req_t            req;
  logic [CW-1:0]       scan_cnt;
  logic [CW-1:0]       scan_lim;
  logic [CW-1:0]       rd_idx;
  logic                rd_vld;
  logic [SW-1:0]       rd_slot;

  // Best bin so far
  logic                found;
  bin_entry_t          best;
  logic [SW-1:0]       best_slot;

  // Store and compare unit hookup
  logic                accept;
  logic                load_ok;
  logic                st_wr_en;
  logic [SW-1:0]       st_wr_addr;
  bin_entry_t          st_wr_entry;
  logic                st_restart;
  bin_entry_t          rd_entry;
  logic                take;
  logic [SPACE_W-1:0]  debit_rem;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign load_ok   = (32'(room_slot_in) < MAX_BINS);
  assign debit_rem = best.rem - req.size;

  // Saturate the scan at the table size.
  assign scan_lim = (CW'(room_count) > CW'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(room_count);

  // Single write port: a load at acceptance, or the debit of the chosen bin.
  always_comb begin
    st_wr_en    = 1'b0;
    st_wr_addr  = SW'(room_slot_in);
    st_wr_entry = '{ident: room_ident_in, cap: room_cap_in, rem: room_cap_in,
                    prio: room_priority_in};
    st_restart  = accept && (cmd == CMD_RESTART);
    if (accept && (cmd == CMD_LOAD) && load_ok) begin
      st_wr_en = 1'b1;
    end else if ((state == ST_FINISH) && found) begin
      st_wr_en        = 1'b1;
      st_wr_addr      = best_slot;
      st_wr_entry     = best;
      st_wr_entry.rem = debit_rem;
    end
  end

  fcap_store #(
    .MAX_BINS (MAX_BINS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (st_wr_en),
    .wr_addr  (st_wr_addr),
    .wr_entry (st_wr_entry),
    .restart  (st_restart),
    .rd_addr  (rd_idx[SW-1:0]),
    .rd_entry (rd_entry)
  );

  fcap_cmp u_cmp (
    .entry    (rd_entry),
    .req      (req),
    .found    (found),
    .best_rem (best.rem),
    .take     (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fit_policy <= POLICY_FIRST;
      room_count <= '0;
      done       <= 1'b0;
      placed     <= 1'b0;
      rd_vld     <= 1'b0;
      rd_idx     <= '0;
      found      <= 1'b0;
    end else begin
      done   <= 1'b0;
      placed <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIT_POLICY: fit_policy <= cfg_data[POLICY_W-1:0];
          REG_ROOM_COUNT: room_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            room_ident_out <= '0;
            room_slot_out  <= '0;
            space_left     <= '0;
            if ((cmd == CMD_ALLOC) && (scan_lim != '0)) begin
              // Latch the request and start the scan at slot zero.
              req      <= '{size: request_size, prio: request_priority,
                            policy: fit_policy};
              scan_cnt <= scan_lim;
              rd_idx   <= '0;
              rd_vld   <= 1'b0;
              found    <= 1'b0;
              state    <= ST_SCAN;
            end else begin
              // Load, restart, unused code, or nothing to scan: empty result.
              done <= 1'b1;
            end
          end
        end

        ST_SCAN: begin
          // Issue one read per cycle; judge the entry read the cycle before.
          rd_vld <= (rd_idx < scan_cnt);
          if (rd_idx < scan_cnt) begin
            rd_slot <= rd_idx[SW-1:0];
            rd_idx  <= rd_idx + CW'(1);
          end
          if (rd_vld && take) begin
            found     <= 1'b1;
            best      <= rd_entry;
            best_slot <= rd_slot;
          end
          if ((rd_idx == scan_cnt) && !rd_vld) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // Debit goes to the store this cycle; present the result.
          state  <= ST_IDLE;
          done   <= 1'b1;
          placed <= found;
          if (found) begin
            room_ident_out <= best.ident;
            room_slot_out  <= SLOT_W'(best_slot);
            space_left     <= debit_rem;
          end else begin
            room_ident_out <= '0;
            room_slot_out  <= '0;
            space_left     <= '0;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a scan is in progress");

  a_placed_done: assert property (@(posedge clk) disable iff (rst)
    placed |-> done)
    else $error("placed raised without a result strobe");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !placed) |-> ((room_ident_out == '0) && (room_slot_out == '0) &&
                           (space_left == '0)))
    else $error("unplaced result carries nonzero fields");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither answered nor in progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= scan_cnt))
    else $error("scan index ran past the scan length");
`endif

endmodule

// File: tb/fit_policy_capacity_allocator_tb.sv
`timescale 1ns / 100ps

module fit_policy_capacity_allocator_tb;
  import fcap_pkg::*;

  localparam int NUM_BINS      = 8;
  localparam int RESET_CYCLES  = 8;
  // settle time covers a full eight-bin allocate with some margin
  localparam int SETTLE_CYCLES = 14;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int PHASES        = 9;
  localparam int MAX_CYCLES    = 400000;
  localparam int SHOW_LIMIT    = 10;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0]    CMD_UNUSED   = 2'd3;
  localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [SLOT_W-1:0]  slot;
    logic [IDENT_W-1:0] ident;
    logic [SPACE_W-1:0] cap;
    logic               bin_prio;
    logic [SPACE_W-1:0] size;
    logic               req_prio;
  } cmd_item_t;

  typedef struct packed {
    logic               placed;
    logic [IDENT_W-1:0] ident;
    logic [SLOT_W-1:0]  slot;
    logic [SPACE_W-1:0] left;
  } placement_t;

  // per item: take the hand-typed placement instead of the computed one
  typedef struct packed {
    logic       fixed;
    placement_t val;
  } pinned_t;

  typedef enum logic {ROW_CMD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    cmd_item_t             item;
    logic                  fixed;
    placement_t            val;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } dir_row_t;

  localparam placement_t NOTHING = '0;

  logic                  clk;
  logic                  rst              = 1'b1;
  logic                  start            = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      cmd              = '0;
  logic [SLOT_W-1:0]     room_slot_in     = '0;
  logic [IDENT_W-1:0]    room_ident_in    = '0;
  logic [SPACE_W-1:0]    room_cap_in      = '0;
  logic                  room_priority_in = 1'b0;
  logic [SPACE_W-1:0]    request_size     = '0;
  logic                  request_priority = 1'b0;
  logic                  done;
  logic                  placed;
  logic [IDENT_W-1:0]    room_ident_out;
  logic [SLOT_W-1:0]     room_slot_out;
  logic [SPACE_W-1:0]    space_left;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  // shadow of the bin table and the two registers
  logic [SPACE_W-1:0]  room_cap   [NUM_BINS];
  logic [SPACE_W-1:0]  room_left  [NUM_BINS];
  logic [IDENT_W-1:0]  room_name  [NUM_BINS];
  logic                room_vip   [NUM_BINS];
  logic [POLICY_W-1:0] cur_policy;
  logic [COUNT_W-1:0]  cur_count;

  placement_t results_due[$];
  pinned_t    pinned[$];
  dir_row_t   dir_rows[$];

  int unsigned bad_count = 0;
  int unsigned shown     = 0;
  int unsigned cycles    = 0;

  fit_policy_capacity_allocator #(.MAX_BINS(NUM_BINS)) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .room_slot_in     (room_slot_in),
    .room_ident_in    (room_ident_in),
    .room_cap_in      (room_cap_in),
    .room_priority_in (room_priority_in),
    .request_size     (request_size),
    .request_priority (request_priority),
    .done             (done),
    .placed           (placed),
    .room_ident_out   (room_ident_out),
    .room_slot_out    (room_slot_out),
    .space_left       (space_left),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: no correct run comes anywhere near this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Apply one command to the shadow table and return the placement it yields.
  function automatic placement_t run_command(cmd_item_t it);
    placement_t  res;
    int unsigned scan;
    int unsigned pick;
    logic        found;
    res   = NOTHING;
    found = 1'b0;
    pick  = 0;
    case (it.op)
      CMD_LOAD: begin
        if (it.slot < NUM_BINS) begin
          room_name[it.slot] = it.ident;
          room_cap[it.slot]  = it.cap;
          room_left[it.slot] = it.cap;
          room_vip[it.slot]  = it.bin_prio;
        end
      end
      CMD_RESTART: begin
        // every slot refills, scanned or not
        for (int j = 0; j < NUM_BINS; j++) room_left[j] = room_cap[j];
      end
      CMD_ALLOC: begin
        // counts past the table size saturate
        scan = (cur_count > NUM_BINS) ? NUM_BINS : cur_count;
        for (int j = 0; j < scan; j++) begin
          if (!(it.req_prio && !room_vip[j]) && room_left[j] >= it.size) begin
            if (!found) begin
              found = 1'b1;
              pick  = j;
              // first fit and the spare code stop at the lowest eligible slot
              if (cur_policy != POLICY_BEST && cur_policy != POLICY_WORST) break;
            end else if (cur_policy == POLICY_BEST && room_left[j] < room_left[pick]) begin
              pick = j;
            end else if (cur_policy == POLICY_WORST && room_left[j] > room_left[pick]) begin
              pick = j;
            end
          end
        end
        if (found) begin
          room_left[pick] = room_left[pick] - it.size;
          res = {1'b1, room_name[pick], SLOT_W'(pick), room_left[pick]};
        end
      end
      default: ;  // unused code leaves everything alone
    endcase
    return res;
  endfunction

  // Score results and track accepted items and register writes, all on the rising edge.
  always @(posedge clk) begin : scoreboard
    placement_t got;
    placement_t want;
    placement_t guess;
    cmd_item_t  seen;
    pinned_t    tag;
    if (rst) begin
      for (int j = 0; j < NUM_BINS; j++) begin
        room_cap[j]  = '0;
        room_left[j] = '0;
        room_name[j] = '0;
        room_vip[j]  = 1'b0;
      end
      cur_policy = POLICY_FIRST;
      cur_count  = '0;
    end else begin
      // check the oldest expectation before queuing anything accepted on this edge
      if (done) begin
        got = {placed, room_ident_out, room_slot_out, space_left};
        if (results_due.size() == 0) begin
          bad_count++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("[%0t] result with nothing outstanding: placed=%0d ident=%0d slot=%0d left=%0d",
                     $time, got.placed, got.ident, got.slot, got.left);
          end
        end else begin
          want = results_due.pop_front();
          if (got.placed !== want.placed || got.ident !== want.ident ||
              got.slot !== want.slot || got.left !== want.left) begin
            bad_count++;
            if (shown < SHOW_LIMIT) begin
              shown++;
              $display("[%0t] mismatch: expected placed=%0d ident=%0d slot=%0d left=%0d",
                       $time, want.placed, want.ident, want.slot, want.left);
              $display("[%0t]           got placed=%0d ident=%0d slot=%0d left=%0d",
                       $time, got.placed, got.ident, got.slot, got.left);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIT_POLICY: cur_policy = cfg_data[POLICY_W-1:0];
          REG_ROOM_COUNT: cur_count  = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        seen  = {cmd, room_slot_in, room_ident_in, room_cap_in, room_priority_in,
                 request_size, request_priority};
        tag   = (pinned.size() != 0) ? pinned.pop_front() : '0;
        guess = run_command(seen);
        results_due.push_back(tag.fixed ? tag.val : guess);
      end
    end
  end

  // Present one item and hold it until the block takes it; start stays high afterward.
  task automatic send_cmd(cmd_item_t it, logic fixed, placement_t val);
    pinned_t tag;
    tag.fixed = fixed;
    tag.val   = val;
    pinned.push_back(tag);
    start            <= 1'b1;
    cmd              <= it.op;
    room_slot_in     <= it.slot;
    room_ident_in    <= it.ident;
    room_cap_in      <= it.cap;
    room_priority_in <= it.bin_prio;
    request_size     <= it.size;
    request_priority <= it.req_prio;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain, let the block settle, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Idle the sender now and then; rarely, hold off until every result is back.
  task automatic pace(int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end else if ($urandom_range(149) == 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (results_due.size() != 0) @(posedge clk);
    end
  endtask

  function automatic cmd_item_t mk_cmd(logic [CMD_W-1:0] op, logic [SLOT_W-1:0] slot,
                                       logic [IDENT_W-1:0] ident, logic [SPACE_W-1:0] cap,
                                       logic bin_prio, logic [SPACE_W-1:0] size,
                                       logic req_prio);
    return {op, slot, ident, cap, bin_prio, size, req_prio};
  endfunction

  function automatic dir_row_t cmd_row(cmd_item_t it, logic fixed, placement_t val);
    return {ROW_CMD, it, fixed, val, {CFG_IDX_W{1'b0}}, {CFG_DATA_W{1'b0}}};
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    return {ROW_REG, cmd_item_t'('0), 1'b0, NOTHING, idx, val};
  endfunction

  // Random item: mostly allocations against loaded bins, some reloads and restarts,
  // a few unused codes. Sizes lean small so requests often land.
  function automatic cmd_item_t random_command();
    cmd_item_t   it;
    int unsigned roll;
    it.slot     = $urandom_range(7);
    it.ident    = $urandom_range(1023);
    it.bin_prio = $urandom_range(1);
    it.req_prio = $urandom_range(1);
    roll = $urandom_range(99);
    if (roll < 8)       it.cap = '0;
    else if (roll < 16) it.cap = '1;
    else                it.cap = $urandom_range(255);
    roll = $urandom_range(99);
    if (roll < 6)       it.size = '0;
    else if (roll < 12) it.size = '1;
    else                it.size = $urandom_range(1, 90);
    roll = $urandom_range(99);
    if (roll < 58)      it.op = CMD_ALLOC;
    else if (roll < 84) it.op = CMD_LOAD;
    else if (roll < 96) it.op = CMD_RESTART;
    else                it.op = CMD_UNUSED;
    return it;
  endfunction

  initial begin : stimulus
    dir_row_t            row;
    cmd_item_t           it;
    int unsigned         idle_pct;
    int unsigned         sent;
    logic [COUNT_W-1:0]  bins_used;

    // Directed part. Registers still hold reset values for the first rows.
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd0, 0), 1'b1, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_LOAD, 0, 0, 0, 0, 8'd0, 0), 1'b1, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_UNUSED, 7, 10'h3FF, 8'hFF, 1, 8'hFF, 1),
                               1'b1, NOTHING));
    dir_rows.push_back(reg_row(REG_ROOM_COUNT, 4'd8));
    dir_rows.push_back(reg_row(REG_FIT_POLICY, {2'b00, POLICY_FIRST}));
    // empty bins still take a zero-size request: slot zero, nothing debited
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd0, 0), 1'b1,
                               {1'b1, 10'd0, 3'd0, 8'd0}));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd1, 1), 1'b1, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_LOAD, 7, 10'h3FF, 8'hFF, 1, 8'd0, 0),
                               1'b1, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_LOAD, 3, 10'h2AA, 8'd100, 0, 8'd0, 0),
                               1'b1, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_LOAD, 5, 10'h155, 8'd40, 1, 8'd0, 0),
                               1'b1, NOTHING));
    // full-size priority request fills the top bin exactly
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'hFF, 1), 1'b1,
                               {1'b1, 10'h3FF, 3'd7, 8'd0}));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd30, 1), 1'b0, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_RESTART, 0, 0, 0, 0, 8'd0, 0), 1'b1, NOTHING));
    dir_rows.push_back(reg_row(REG_FIT_POLICY, {2'b00, POLICY_BEST}));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd30, 0), 1'b0, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'hFF, 0), 1'b0, NOTHING));
    dir_rows.push_back(reg_row(REG_FIT_POLICY, {2'b00, POLICY_WORST}));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd30, 0), 1'b0, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd200, 1), 1'b0, NOTHING));
    // spare policy code behaves as first fit
    dir_rows.push_back(reg_row(REG_FIT_POLICY, {2'b11, POLICY_SPARE}));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd10, 0), 1'b0, NOTHING));
    // count beyond the table saturates
    dir_rows.push_back(reg_row(REG_ROOM_COUNT, 4'd15));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd1, 1), 1'b0, NOTHING));
    // shrink the scan so the priority bins drop out of view
    dir_rows.push_back(reg_row(REG_ROOM_COUNT, 4'd4));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'd1, 1), 1'b0, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_LOAD, 2, 10'h3FF, 8'hFF, 1, 8'd0, 0),
                               1'b1, NOTHING));
    dir_rows.push_back(cmd_row(mk_cmd(CMD_ALLOC, 0, 0, 0, 0, 8'hFF, 1), 1'b0, NOTHING));

    // hold reset, then release it for good
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) write_reg(row.reg_idx, row.reg_val);
      else send_cmd(row.item, row.fixed, row.val);
    end

    // Random phases: each one rewrites both registers, reloads every slot,
    // then runs a random mix under its own idle pattern.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_FIT_POLICY, {2'($urandom_range(3)), 2'(p % 4)});
      case (p)
        0, 2, 5: bins_used = 4'd8;
        1:       bins_used = 4'd15;
        3:       bins_used = 4'd1;
        4:       bins_used = 4'd5;
        6:       bins_used = 4'd2;
        7:       bins_used = 4'd12;
        default: bins_used = $urandom_range(15);
      endcase
      write_reg(REG_ROOM_COUNT, bins_used);
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 82;
        default: idle_pct = 14;
      endcase
      sent = 0;
      // load every slot first so allocations have bins to choose from
      for (int s = 0; s < NUM_BINS; s++) begin
        it      = random_command();
        it.op   = CMD_LOAD;
        it.slot = s;
        send_cmd(it, 1'b0, NOTHING);
        pace(idle_pct);
        sent++;
      end
      while (sent < RANDOM_ITEMS / PHASES) begin
        it = random_command();
        send_cmd(it, 1'b0, NOTHING);
        pace(idle_pct);
        if (it.op != CMD_UNUSED) sent++;
      end
    end

    // drop start, wait out every outstanding result, then give the block a tail
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_count == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fcap_pkg.sv
rtl/fcap_store.sv
rtl/fcap_cmp.sv
rtl/fit_policy_capacity_allocator.sv
tb/fit_policy_capacity_allocator_tb.sv
